[hdl/gstc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gstc_pkg - shared types and constants of the gimbal scan/track controller
// Mode codes, register indexes, field widths and the status bundle.
// ----------------------------------------------------------------------------
package gstc_pkg;

    localparam int ANGLE_BITS_DEF = 9;
    localparam int STEP_BITS      = 7;
    localparam int DB_BITS        = 8;
    localparam int CFG_IDX_BITS   = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_PITCH_STEP = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROLL_STEP  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PITCH_MAX  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_PITCH_MIN  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROLL_MAX   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROLL_MIN   = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEADBAND   = 3'd6;

    // Register reset values
    localparam int RST_STEP      = 10;
    localparam int RST_LIMIT_HI  = 90;
    localparam int RST_LIMIT_LO  = -90;
    localparam int RST_DEADBAND  = 5;

    typedef enum logic [1:0] {
        MODE_INIT    = 2'd0,
        MODE_SEARCH  = 2'd1,
        MODE_OVERSEE = 2'd2,
        MODE_TRACK   = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t mode;
        logic  locked;
    } status_t;

endpackage

[hdl/gstc_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gstc_cfg - configuration register file
// Holds raster steps, axis limits and the tracking deadband; write only.
// ----------------------------------------------------------------------------
module gstc_cfg #(
    parameter int ANGLE_BITS = gstc_pkg::ANGLE_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [gstc_pkg::CFG_IDX_BITS-1:0]    cfg_addr,
    input  logic [ANGLE_BITS-1:0]                cfg_wdata,
    output logic [gstc_pkg::STEP_BITS-1:0]       pitch_step,
    output logic [gstc_pkg::STEP_BITS-1:0]       roll_step,
    output logic signed [ANGLE_BITS-1:0]         pitch_max,
    output logic signed [ANGLE_BITS-1:0]         pitch_min,
    output logic signed [ANGLE_BITS-1:0]         roll_max,
    output logic signed [ANGLE_BITS-1:0]         roll_min,
    output logic [gstc_pkg::DB_BITS-1:0]         deadband
);

    logic [gstc_pkg::STEP_BITS-1:0] pitch_step_reg;
    logic [gstc_pkg::STEP_BITS-1:0] roll_step_reg;
    logic signed [ANGLE_BITS-1:0]   pitch_max_reg;
    logic signed [ANGLE_BITS-1:0]   pitch_min_reg;
    logic signed [ANGLE_BITS-1:0]   roll_max_reg;
    logic signed [ANGLE_BITS-1:0]   roll_min_reg;
    logic [gstc_pkg::DB_BITS-1:0]   deadband_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_step_reg <= gstc_pkg::STEP_BITS'(gstc_pkg::RST_STEP);
            roll_step_reg  <= gstc_pkg::STEP_BITS'(gstc_pkg::RST_STEP);
            pitch_max_reg  <= ANGLE_BITS'(gstc_pkg::RST_LIMIT_HI);
            pitch_min_reg  <= ANGLE_BITS'(gstc_pkg::RST_LIMIT_LO);
            roll_max_reg   <= ANGLE_BITS'(gstc_pkg::RST_LIMIT_HI);
            roll_min_reg   <= ANGLE_BITS'(gstc_pkg::RST_LIMIT_LO);
            deadband_reg   <= gstc_pkg::DB_BITS'(gstc_pkg::RST_DEADBAND);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                gstc_pkg::REG_PITCH_STEP: begin
                    pitch_step_reg <= cfg_wdata[gstc_pkg::STEP_BITS-1:0];
                end
                gstc_pkg::REG_ROLL_STEP: begin
                    roll_step_reg <= cfg_wdata[gstc_pkg::STEP_BITS-1:0];
                end
                gstc_pkg::REG_PITCH_MAX: pitch_max_reg <= cfg_wdata;
                gstc_pkg::REG_PITCH_MIN: pitch_min_reg <= cfg_wdata;
                gstc_pkg::REG_ROLL_MAX:  roll_max_reg  <= cfg_wdata;
                gstc_pkg::REG_ROLL_MIN:  roll_min_reg  <= cfg_wdata;
                gstc_pkg::REG_DEADBAND: begin
                    deadband_reg <= cfg_wdata[gstc_pkg::DB_BITS-1:0];
                end
                default: ;
            endcase
        end
    end

    assign pitch_step = pitch_step_reg;
    assign roll_step  = roll_step_reg;
    assign pitch_max  = pitch_max_reg;
    assign pitch_min  = pitch_min_reg;
    assign roll_max   = roll_max_reg;
    assign roll_min   = roll_min_reg;
    assign deadband   = deadband_reg;

endmodule

[hdl/gstc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gstc_ctrl - mode state machine and gimbal angle registers
// One tick per advance: park, raster search or deadband tracking.
// ----------------------------------------------------------------------------
module gstc_ctrl #(
    parameter int ANGLE_BITS = gstc_pkg::ANGLE_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 advance,
    input  logic                                 active_mode,
    input  logic                                 target_found,
    input  logic signed [ANGLE_BITS-1:0]         pitch_error,
    input  logic signed [ANGLE_BITS-1:0]         roll_error,
    input  logic [gstc_pkg::STEP_BITS-1:0]       pitch_step,
    input  logic [gstc_pkg::STEP_BITS-1:0]       roll_step,
    input  logic signed [ANGLE_BITS-1:0]         pitch_max,
    input  logic signed [ANGLE_BITS-1:0]         pitch_min,
    input  logic signed [ANGLE_BITS-1:0]         roll_max,
    input  logic signed [ANGLE_BITS-1:0]         roll_min,
    input  logic [gstc_pkg::DB_BITS-1:0]         deadband,
    output logic signed [ANGLE_BITS-1:0]         pitch_angle,
    output logic signed [ANGLE_BITS-1:0]         roll_angle,
    output gstc_pkg::status_t                    status
);

    // two guard bits cover angle plus step and the negated deadband
    localparam int EXT = ANGLE_BITS + 2;

    gstc_pkg::mode_t              mode_reg, mode_next;
    logic signed [ANGLE_BITS-1:0] pitch_reg, pitch_next;
    logic signed [ANGLE_BITS-1:0] roll_reg, roll_next;
    logic                         pitch_down_reg, pitch_down_next;
    logic                         roll_up_reg, roll_up_next;
    logic                         locked_reg, locked_next;

    logic signed [EXT-1:0] p_x, r_x, pmax_x, pmin_x, rmax_x, rmin_x;
    logic signed [EXT-1:0] ps_x, rs_x, db_x, perr_x, rerr_x;
    logic signed [EXT-1:0] p_up_sum, p_dn_sum, r_up_sum, r_dn_sum;
    logic signed [EXT-1:0] p_up, p_dn, r_up, r_dn;
    logic signed [EXT-1:0] p_trk, r_trk, p_clh, r_clh, p_cl, r_cl;

    always_comb begin
        p_x    = {{2{pitch_reg[ANGLE_BITS-1]}}, pitch_reg};
        r_x    = {{2{roll_reg[ANGLE_BITS-1]}}, roll_reg};
        pmax_x = {{2{pitch_max[ANGLE_BITS-1]}}, pitch_max};
        pmin_x = {{2{pitch_min[ANGLE_BITS-1]}}, pitch_min};
        rmax_x = {{2{roll_max[ANGLE_BITS-1]}}, roll_max};
        rmin_x = {{2{roll_min[ANGLE_BITS-1]}}, roll_min};
        perr_x = {{2{pitch_error[ANGLE_BITS-1]}}, pitch_error};
        rerr_x = {{2{roll_error[ANGLE_BITS-1]}}, roll_error};
        ps_x   = $signed({{(EXT-gstc_pkg::STEP_BITS){1'b0}}, pitch_step});
        rs_x   = $signed({{(EXT-gstc_pkg::STEP_BITS){1'b0}}, roll_step});
        db_x   = $signed({{(EXT-gstc_pkg::DB_BITS){1'b0}}, deadband});

        // raster moves, each stopped at the limit it heads for
        p_up_sum = p_x + ps_x;
        p_dn_sum = p_x - ps_x;
        r_up_sum = r_x + rs_x;
        r_dn_sum = r_x - rs_x;
        p_up = (p_up_sum < pmax_x) ? p_up_sum : pmax_x;
        p_dn = (p_dn_sum > pmin_x) ? p_dn_sum : pmin_x;
        r_up = (r_up_sum < rmax_x) ? r_up_sum : rmax_x;
        r_dn = (r_dn_sum > rmin_x) ? r_dn_sum : rmin_x;

        // tracking nudge, then clamp high first so the low limit wins
        p_trk = p_x;
        if (perr_x > db_x) begin
            p_trk = p_x - EXT'(1);
        end else if (perr_x < -db_x) begin
            p_trk = p_x + EXT'(1);
        end
        r_trk = r_x;
        if (rerr_x > db_x) begin
            r_trk = r_x + EXT'(1);
        end else if (rerr_x < -db_x) begin
            r_trk = r_x - EXT'(1);
        end
        p_clh = (p_trk >= pmax_x) ? pmax_x : p_trk;
        r_clh = (r_trk >= rmax_x) ? rmax_x : r_trk;
        p_cl  = (p_clh <= pmin_x) ? pmin_x : p_clh;
        r_cl  = (r_clh <= rmin_x) ? rmin_x : r_clh;
    end

    // next mode
    always_comb begin
        mode_next = mode_reg;
        if (!active_mode) begin
            mode_next = gstc_pkg::MODE_OVERSEE;
        end else begin
            case (mode_reg)
                gstc_pkg::MODE_INIT,
                gstc_pkg::MODE_OVERSEE: mode_next = gstc_pkg::MODE_SEARCH;
                gstc_pkg::MODE_SEARCH: begin
                    mode_next = target_found ? gstc_pkg::MODE_TRACK : gstc_pkg::MODE_SEARCH;
                end
                gstc_pkg::MODE_TRACK: begin
                    mode_next = target_found ? gstc_pkg::MODE_TRACK : gstc_pkg::MODE_SEARCH;
                end
                default: mode_next = gstc_pkg::MODE_SEARCH;
            endcase
        end
    end

    // angles, raster directions and lock flag
    always_comb begin
        pitch_next      = pitch_reg;
        roll_next       = roll_reg;
        pitch_down_next = pitch_down_reg;
        roll_up_next    = roll_up_reg;
        locked_next     = locked_reg;
        if (!active_mode) begin
            pitch_next = '0;
            roll_next  = '0;
        end else begin
            case (mode_reg)
                gstc_pkg::MODE_INIT,
                gstc_pkg::MODE_OVERSEE: begin
                    pitch_next = '0;
                    roll_next  = '0;
                end
                gstc_pkg::MODE_SEARCH: begin
                    if (!target_found) begin
                        if (roll_up_reg && (r_x < rmax_x)) begin
                            roll_next = r_up[ANGLE_BITS-1:0];
                        end else if (r_x > rmin_x) begin
                            roll_up_next = 1'b0;
                            roll_next    = r_dn[ANGLE_BITS-1:0];
                        end else begin
                            // roll sweep done: step pitch one row
                            roll_up_next = 1'b1;
                            if (pitch_down_reg && (p_x > pmin_x)) begin
                                pitch_next = p_dn[ANGLE_BITS-1:0];
                            end else if (p_x < pmax_x) begin
                                pitch_down_next = 1'b0;
                                pitch_next      = p_up[ANGLE_BITS-1:0];
                            end else begin
                                pitch_down_next = 1'b1;
                                if (p_x > pmin_x) begin
                                    pitch_next = p_dn[ANGLE_BITS-1:0];
                                end
                            end
                        end
                    end
                end
                gstc_pkg::MODE_TRACK: begin
                    pitch_next = p_cl[ANGLE_BITS-1:0];
                    roll_next  = r_cl[ANGLE_BITS-1:0];
                    if (target_found) begin
                        locked_next = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= gstc_pkg::MODE_INIT;
            pitch_reg      <= '0;
            roll_reg       <= '0;
            pitch_down_reg <= 1'b1;
            roll_up_reg    <= 1'b1;
            locked_reg     <= 1'b0;
        end else if (advance) begin
            mode_reg       <= mode_next;
            pitch_reg      <= pitch_next;
            roll_reg       <= roll_next;
            pitch_down_reg <= pitch_down_next;
            roll_up_reg    <= roll_up_next;
            locked_reg     <= locked_next;
        end
    end

    assign pitch_angle   = pitch_reg;
    assign roll_angle    = roll_reg;
    assign status.mode   = mode_reg;
    assign status.locked = locked_reg;

endmodule

[hdl/gimbal_scan_track_controller_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gimbal_scan_track_controller_core - gimbal scan and track controller
// Input register, one-tick control step, angle/mode result register.
// ----------------------------------------------------------------------------
// Path: an accepted item is held in the input register, then the control step
//   writes the angle and mode registers that drive m_*.
// Throughput: one item per cycle while m_ready is high; the registered
//   control step sets the rate.
// Reset: synchronous; parks at (0,0) in init, registers back to defaults.
module gimbal_scan_track_controller_core #(
    parameter int ANGLE_BITS = gstc_pkg::ANGLE_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [gstc_pkg::CFG_IDX_BITS-1:0] cfg_addr,
    input  logic [ANGLE_BITS-1:0]             cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_active_mode,
    input  logic                              s_target_found,
    input  logic signed [ANGLE_BITS-1:0]      s_pitch_error,
    input  logic signed [ANGLE_BITS-1:0]      s_roll_error,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [ANGLE_BITS-1:0]      m_pitch_cmd,
    output logic signed [ANGLE_BITS-1:0]      m_roll_cmd,
    output logic [1:0]                        m_mode,
    output logic                              m_tracking_locked
);

    logic [gstc_pkg::STEP_BITS-1:0] pitch_step, roll_step;
    logic signed [ANGLE_BITS-1:0]   pitch_max, pitch_min, roll_max, roll_min;
    logic [gstc_pkg::DB_BITS-1:0]   deadband;

    logic                           in_valid_reg;
    logic                           active_reg, found_reg;
    logic signed [ANGLE_BITS-1:0]   perr_reg, rerr_reg;
    logic                           out_valid_reg;
    logic                           advance;
    gstc_pkg::status_t              status;

    // step the controller when the result slot is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            active_reg <= s_active_mode;
            found_reg  <= s_target_found;
            perr_reg   <= s_pitch_error;
            rerr_reg   <= s_roll_error;
        end
    end

    gstc_cfg #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .pitch_step(pitch_step),
        .roll_step (roll_step),
        .pitch_max (pitch_max),
        .pitch_min (pitch_min),
        .roll_max  (roll_max),
        .roll_min  (roll_min),
        .deadband  (deadband)
    );

    gstc_ctrl #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .active_mode (active_reg),
        .target_found(found_reg),
        .pitch_error (perr_reg),
        .roll_error  (rerr_reg),
        .pitch_step  (pitch_step),
        .roll_step   (roll_step),
        .pitch_max   (pitch_max),
        .pitch_min   (pitch_min),
        .roll_max    (roll_max),
        .roll_min    (roll_min),
        .deadband    (deadband),
        .pitch_angle (m_pitch_cmd),
        .roll_angle  (m_roll_cmd),
        .status      (status)
    );

    assign m_valid           = out_valid_reg;
    assign m_mode            = status.mode;
    assign m_tracking_locked = status.locked;

endmodule

[hdl/gstc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gstc_checker - port-level checks for the gimbal scan/track controller
// Watches the result channel; bound to the top level.
// ----------------------------------------------------------------------------
module gstc_checker #(
    parameter int ANGLE_BITS = gstc_pkg::ANGLE_BITS_DEF
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic signed [ANGLE_BITS-1:0] m_pitch_cmd,
    input logic signed [ANGLE_BITS-1:0] m_roll_cmd,
    input logic [1:0]                   m_mode,
    input logic                         m_tracking_locked
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pitch_cmd) && $stable(m_roll_cmd)
            && $stable(m_mode) && $stable(m_tracking_locked))
        else $error("result changed while stalled");

    // every tick leaves init
    a_no_init: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_mode != gstc_pkg::MODE_INIT)
        else $error("result reports init mode");

    // oversee parks the gimbal
    a_oversee_park: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_mode == gstc_pkg::MODE_OVERSEE |-> m_pitch_cmd == '0 && m_roll_cmd == '0)
        else $error("oversee result not parked at zero");

    // lock is sticky until reset
    a_lock_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tracking_locked |=> m_tracking_locked)
        else $error("tracking lock dropped without reset");

endmodule

bind gimbal_scan_track_controller_core gstc_checker #(
    .ANGLE_BITS(ANGLE_BITS)
) u_gstc_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_pitch_cmd      (m_pitch_cmd),
    .m_roll_cmd       (m_roll_cmd),
    .m_mode           (m_mode),
    .m_tracking_locked(m_tracking_locked)
);
